@@ rtl/core/signed_int_to_decimal_ascii_macros.svh @@
// Assertion macros shared by the RTL of the decimal text converter.
// Each one expects signals named clk and rst_n in the calling scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SIDASC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SIDASC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sidasc_pkg.sv @@
package sidasc_pkg;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigitW = 4;

  // Longest decimal text of a 32-bit magnitude
  localparam int unsigned MaxDigits = 10;

  // Character codes
  localparam logic [CharW-1:0] CharMinus = 7'd45;
  localparam logic [CharW-1:0] CharZero  = 7'd48;

  // Exact divide by ten for any 32-bit value: (x * Recip10) >> Recip10Shift
  localparam logic [ValueW-1:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned       Recip10Shift = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT
  } sidasc_state_t;

endpackage

@@ rtl/core/sidasc_if.sv @@
// Input channel: one signed integer per transaction
interface sidasc_in_if import sidasc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one character per transaction
interface sidasc_out_if import sidasc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// The first character is offered once the division state has produced every digit.
// A new number is accepted only after the final character of the previous one is taken;
// a negative number gets a minus sign first; each character waits as long as the sink stalls.
// One shared divide-by-ten unit (reciprocal multiply) produces one digit per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any number in work.
module signed_int_to_decimal_ascii
  import sidasc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigits
) (
  input  logic        clk,
  input  logic        rst_n,
  sidasc_in_if.sink   in_ch,
  sidasc_out_if.source out_ch
);

  `include "signed_int_to_decimal_ascii_macros.svh"

  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ProdW = 2 * ValueW;

  sidasc_state_t state_r, state_nxt;

  logic [ValueW-1:0] mag_r;
  logic              neg_r;
  logic [CntW-1:0]   cnt_r;
  logic [DigitW-1:0] digs_r [MAX_DIGITS];

  logic [ProdW-1:0]  prod;
  logic [ValueW-1:0] quo;
  logic [DigitW-1:0] ten_q_lo;
  logic [DigitW-1:0] rem;
  logic              quo_zero;
  logic              in_fire;
  logic              out_fire;
  logic              last_char;

  // Shared divide-by-ten unit; the remainder needs only the low nibble
  always_comb begin
    prod     = ProdW'(mag_r) * ProdW'(Recip10);
    quo      = ValueW'(prod >> Recip10Shift);
    ten_q_lo = DigitW'({quo[DigitW-1:0], 3'b000}) + DigitW'({quo[DigitW-1:0], 1'b0});
    rem      = mag_r[DigitW-1:0] - ten_q_lo;
    quo_zero = (quo == '0);
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign last_char = (state_r == ST_DIGIT) && (cnt_r == CntW'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (quo_zero) state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_ch.ready) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ch.ready && last_char) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and result payload
  always_comb begin
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    out_ch.char_code = CharZero + CharW'(digs_r[0]);
    out_ch.last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_DIV: begin
        out_ch.valid = 1'b0;
      end
      ST_SIGN: begin
        out_ch.valid     = 1'b1;
        out_ch.char_code = CharMinus;
      end
      ST_DIGIT: begin
        out_ch.valid = 1'b1;
        out_ch.last  = last_char;
      end
      default: in_ch.ready = 1'b0;
    endcase
  end

  // Sequencer and digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (out_fire && state_r == ST_DIGIT) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  // Magnitude and digit store: push digits least significant first, pop from the front
  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg_r <= in_ch.value[ValueW-1];
      mag_r <= in_ch.value[ValueW-1] ? (ValueW'(0) - ValueW'(in_ch.value))
                                     : ValueW'(in_ch.value);
    end else if (state_r == ST_DIV) begin
      mag_r     <= quo;
      digs_r[0] <= rem;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digs_r[i] <= digs_r[i-1];
      end
    end else if (out_fire && state_r == ST_DIGIT) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digs_r[i] <= digs_r[i+1];
      end
    end
  end

  `SIDASC_ASSERT_NEXT(a_accept_divides, in_fire, state_r == ST_DIV,
    "accepted number did not start division")
  `SIDASC_ASSERT_NEXT(a_div_ends, (state_r == ST_DIV) && quo_zero,
    (state_r == ST_SIGN) || (state_r == ST_DIGIT), "division did not end at zero quotient")
  `SIDASC_ASSERT_NOW(a_sign_only_neg, state_r == ST_SIGN, neg_r,
    "minus sign offered for a non-negative number")
  `SIDASC_ASSERT_NOW(a_digits_pending, state_r == ST_DIGIT,
    (cnt_r != '0) && (cnt_r <= CntW'(MAX_DIGITS)), "digit emitted with empty digit store")
  `SIDASC_ASSERT_NEXT(a_last_to_idle, out_fire && out_ch.last, state_r == ST_IDLE,
    "sequencer not idle after final character")

endmodule
